FILE: hw/rtl/sacl_pkg.sv
// Shared constants, types and the lookup result for the set-associative cache.
package sacl_pkg;

  // Cache geometry. Each of the MAX_WAYS banks holds one way position of every row.
  localparam int ENTRIES  = 256;
  localparam int MAX_WAYS = 8;
  localparam int ENTRY_W  = $clog2(ENTRIES);
  localparam int BANK_W   = $clog2(MAX_WAYS);
  localparam int ROW_W    = ENTRY_W - BANK_W;
  localparam int ROWS     = ENTRIES / MAX_WAYS;

  // Field widths.
  localparam int ADDR_W = 32;
  localparam int AGE_W  = 3;
  localparam int WAY_W  = 3;
  localparam int CFG_W  = 2;
  localparam int HITS_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [BANK_W-1:0] bank_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  // Decision made for one access, with the new ages for every bank of the set.
  typedef struct packed {
    logic                      hit;
    logic [WAY_W-1:0]          way;
    logic                      evicted;
    addr_t                     victim;
    bank_t                     slot_bank;
    logic [MAX_WAYS-1:0]       set_banks;
    age_t [MAX_WAYS-1:0]       age_new;
  } lookup_res_t;

endpackage

FILE: hw/rtl/sacl_ram.sv
// Simple dual-port RAM with registered read and write-first forwarding.
module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the same row in the same cycle is passed through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/sacl_lookup.sv
// Tag compare, fill and victim selection, and age update for one set.
module sacl_lookup (
  input  sacl_pkg::cfg_t                      ways_log2,
  input  sacl_pkg::bank_t                     base_lo,
  input  sacl_pkg::addr_t                     address,
  input  sacl_pkg::addr_t [sacl_pkg::MAX_WAYS-1:0] bank_addr,
  input  sacl_pkg::age_t  [sacl_pkg::MAX_WAYS-1:0] bank_age,
  input  logic [sacl_pkg::MAX_WAYS-1:0]       bank_valid,
  output sacl_pkg::lookup_res_t               res
);

  sacl_pkg::bank_t             lo_mask;
  sacl_pkg::age_t              top_age;
  logic [sacl_pkg::MAX_WAYS-1:0] sel;
  logic [sacl_pkg::MAX_WAYS-1:0] hit_vec;
  logic [sacl_pkg::MAX_WAYS-1:0] empty_vec;
  logic                        any_hit;
  logic                        any_empty;
  sacl_pkg::bank_t             hit_bank;
  sacl_pkg::bank_t             empty_bank;
  sacl_pkg::bank_t             victim_bank;
  sacl_pkg::bank_t             slot_bank;
  sacl_pkg::age_t              best_age;
  logic                        best_found;
  sacl_pkg::age_t              hit_age;

  // Ways in use form the low bits of the bank number; the rest must match the set base.
  assign lo_mask = ~(sacl_pkg::bank_t'('1) << ways_log2);
  assign top_age = sacl_pkg::age_t'(lo_mask);

  always_comb begin
    for (int b = 0; b < sacl_pkg::MAX_WAYS; b++) begin
      sel[b]       = ((sacl_pkg::bank_t'(b) & ~lo_mask) == base_lo);
      hit_vec[b]   = sel[b] && bank_valid[b] && (bank_addr[b] == address);
      empty_vec[b] = sel[b] && !bank_valid[b];
    end
  end

  assign any_hit   = |hit_vec;
  assign any_empty = |empty_vec;

  // Lowest matching bank wins, both for hits and for empty lines.
  always_comb begin
    hit_bank   = '0;
    empty_bank = '0;
    for (int b = sacl_pkg::MAX_WAYS - 1; b >= 0; b--) begin
      if (hit_vec[b]) begin
        hit_bank = sacl_pkg::bank_t'(b);
      end
      if (empty_vec[b]) begin
        empty_bank = sacl_pkg::bank_t'(b);
      end
    end
  end

  // Oldest line of the set is the victim; ties go to the lower way.
  always_comb begin
    best_age    = '0;
    best_found  = 1'b0;
    victim_bank = '0;
    for (int b = 0; b < sacl_pkg::MAX_WAYS; b++) begin
      if (sel[b] && (!best_found || (bank_age[b] > best_age))) begin
        best_age    = bank_age[b];
        victim_bank = sacl_pkg::bank_t'(b);
        best_found  = 1'b1;
      end
    end
  end

  assign slot_bank = any_hit ? hit_bank : (any_empty ? empty_bank : victim_bank);
  assign hit_age   = bank_age[hit_bank];

  // The touched line becomes youngest; other valid lines age by one, saturating (on a hit, only younger ones).
  always_comb begin
    res.hit       = any_hit;
    res.way       = sacl_pkg::WAY_W'(slot_bank & lo_mask);
    res.evicted   = !any_hit && !any_empty;
    res.victim    = res.evicted ? bank_addr[victim_bank] : '0;
    res.slot_bank = slot_bank;
    res.set_banks = sel;
    for (int b = 0; b < sacl_pkg::MAX_WAYS; b++) begin
      if (sacl_pkg::bank_t'(b) == slot_bank) begin
        res.age_new[b] = '0;
      end else if (bank_valid[b] && (bank_age[b] < top_age) &&
                   (!any_hit || (bank_age[b] < hit_age))) begin
        res.age_new[b] = bank_age[b] + sacl_pkg::age_t'(1);
      end else begin
        res.age_new[b] = bank_age[b];
      end
    end
  end

endmodule

FILE: hw/rtl/set_assoc_cache_lru.sv
// Channel   Direction  Handshake         Word
// in        input      in_valid/in_stall   in_address
// out       output     out_valid/out_stall out_hit, out_way, out_evicted,
//                                          out_victim_address, out_hit_total
// cfg       input      cfg_wr_en           cfg_wr_data (ways_log2)
//
// One access is accepted per cycle while in_stall is low; its result word passes the
// lookup stage and the result register. The access reads all ways of its set from the
// eight address and age RAM banks at acceptance; the decision and write-back happen as
// the lookup stage moves on, with a same-row write forwarded into the following read.
// Reset clears all line valid bits, the hit count and the register at once.
// A stall on the result side holds the result register and then the lookup stage.
module set_assoc_cache_lru (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sacl_pkg::addr_t        in_address,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [sacl_pkg::WAY_W-1:0] out_way,
  output logic                   out_evicted,
  output sacl_pkg::addr_t        out_victim_address,
  output logic [sacl_pkg::HITS_W-1:0] out_hit_total,
  input  logic                   cfg_wr_en,
  input  sacl_pkg::cfg_t         cfg_wr_data
);

  sacl_pkg::cfg_t          ways_log2_r;
  logic                    accept;
  logic                    s1_go;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  sacl_pkg::addr_t         s1_addr_r;
  sacl_pkg::row_t          s1_row_r;
  sacl_pkg::bank_t         s1_base_lo_r;
  logic [sacl_pkg::ENTRY_W-1:0] set_mask;
  logic [sacl_pkg::ENTRY_W-1:0] base;
  sacl_pkg::addr_t [sacl_pkg::MAX_WAYS-1:0] bank_addr;
  sacl_pkg::age_t  [sacl_pkg::MAX_WAYS-1:0] bank_age;
  logic [sacl_pkg::MAX_WAYS-1:0] bank_valid;
  logic [sacl_pkg::MAX_WAYS-1:0][sacl_pkg::ROWS-1:0] valid_r;
  logic [sacl_pkg::HITS_W-1:0] hits_r;
  logic [sacl_pkg::HITS_W-1:0] hits_nxt;
  sacl_pkg::lookup_res_t   res;
  logic                    out_valid_r;
  logic                    out_valid_nxt;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_log2_r <= '0;
    end else if (cfg_wr_en) begin
      ways_log2_r <= cfg_wr_data;
    end
  end

  // Handshake: the lookup stage moves on when the result register is free.
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  // Set base entry: set index shifted up by log2 of the way count; its row picks the RAM word.
  assign set_mask = sacl_pkg::ENTRY_W'(sacl_pkg::ENTRIES - 1) >> ways_log2_r;
  assign base     = (in_address[sacl_pkg::ENTRY_W-1:0] & set_mask) << ways_log2_r;

  assign s1_valid_nxt = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  // Lookup stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r    <= in_address;
      s1_row_r     <= base[sacl_pkg::ENTRY_W-1:sacl_pkg::BANK_W];
      s1_base_lo_r <= base[sacl_pkg::BANK_W-1:0];
    end
  end

  // One address RAM and one age RAM per way position.
  for (genvar b = 0; b < sacl_pkg::MAX_WAYS; b++) begin : g_bank
    sacl_ram #(
      .WIDTH(sacl_pkg::ADDR_W),
      .DEPTH(sacl_pkg::ROWS)
    ) u_addr_ram (
      .clk     (clk),
      .wr_en   (s1_go && !res.hit && (res.slot_bank == sacl_pkg::bank_t'(b))),
      .wr_addr (s1_row_r),
      .wr_data (s1_addr_r),
      .rd_en   (accept),
      .rd_addr (base[sacl_pkg::ENTRY_W-1:sacl_pkg::BANK_W]),
      .rd_data (bank_addr[b])
    );

    sacl_ram #(
      .WIDTH(sacl_pkg::AGE_W),
      .DEPTH(sacl_pkg::ROWS)
    ) u_age_ram (
      .clk     (clk),
      .wr_en   (s1_go && res.set_banks[b]),
      .wr_addr (s1_row_r),
      .wr_data (res.age_new[b]),
      .rd_en   (accept),
      .rd_addr (base[sacl_pkg::ENTRY_W-1:sacl_pkg::BANK_W]),
      .rd_data (bank_age[b])
    );

    assign bank_valid[b] = valid_r[b][s1_row_r];
  end

  // Line valid bits, set when a miss fills its slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (s1_go && !res.hit) begin
      valid_r[res.slot_bank][s1_row_r] <= 1'b1;
    end
  end

  sacl_lookup u_lookup (
    .ways_log2  (ways_log2_r),
    .base_lo    (s1_base_lo_r),
    .address    (s1_addr_r),
    .bank_addr  (bank_addr),
    .bank_age   (bank_age),
    .bank_valid (bank_valid),
    .res        (res)
  );

  // Running hit count.
  assign hits_nxt = hits_r + sacl_pkg::HITS_W'(res.hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0;
    end else if (s1_go) begin
      hits_r <= hits_nxt;
    end
  end

  // Result register.
  assign out_valid_nxt = s1_go ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_hit            <= res.hit;
      out_way            <= res.way;
      out_evicted        <= res.evicted;
      out_victim_address <= res.victim;
      out_hit_total      <= hits_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> !(res.hit && res.evicted))
    else $error("hit and eviction reported together");

  // Eviction only when every line of the set is valid.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res.evicted) |-> ((bank_valid & res.set_banks) == res.set_banks))
    else $error("eviction while the set had an empty line");

  // The chosen slot lies inside the addressed set.
  a_slot_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> res.set_banks[res.slot_bank])
    else $error("slot outside the addressed set");

  // A held lookup keeps its word.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_addr_r)))
    else $error("held lookup word lost");

endmodule
